@@ src/brr_pkg.sv @@
package brr_pkg;

	localparam int PAGE_COUNT_DEF = 4096;
	localparam int TOP_ORDER_DEF  = 10;

	localparam int ADDR_W  = 40;
	localparam int CNT_W   = 13;
	localparam int ORD_W   = 4;
	localparam int PAGE_SH = 12;
	localparam int FIRST_W = ADDR_W - PAGE_SH;
	localparam int END_W   = 30;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] base_address;
		logic [ADDR_W-1:0] length_bytes;
	} req_t;

	typedef struct packed {
		logic [ORD_W-1:0] order;
		logic [CNT_W-1:0] free_blocks;
		logic             last;
	} rsp_t;

	typedef struct packed {
		logic             free;
		logic [ORD_W-1:0] ord;
	} ent_t;

	localparam logic CMD_RESERVE = 1'b0;
	localparam logic CMD_REINIT  = 1'b1;

endpackage

@@ src/buddy_range_reserve_unit.sv @@
// buddy free-block map over PAGE_COUNT pages of 4 KB
//
// req channel (valid/stall): one beat is either a reserve of a byte range
// or a reinitialize. rsp channel (valid/stall): every request is answered
// with TOP_ORDER + 1 beats, the free-block count of each order from the
// highest down to order zero; last marks the order-zero beat.
//
// a reserve walks every block head of every order through one shared
// compare unit and a page memory with one read and one write port: each
// head visited is read, then examined, and a split whose buddy lies in the
// map adds a buddy write. a zero length goes straight to the report. a
// reinitialize sweeps the page memory once, one page per cycle.
//
// after reset the same sweep runs before the first request is taken.
// req_stall stays high from acceptance until the last report beat is
// taken; a stall on rsp simply holds the current report beat.
module buddy_range_reserve_unit #(
	parameter int PAGE_COUNT = brr_pkg::PAGE_COUNT_DEF,
	parameter int TOP_ORDER  = brr_pkg::TOP_ORDER_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  brr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output brr_pkg::rsp_t rsp
);
	import brr_pkg::*;

	localparam int AW  = $clog2(PAGE_COUNT);
	localparam int EW  = ((AW > TOP_ORDER) ? AW : TOP_ORDER) + 2;
	localparam int TOP = (PAGE_COUNT + (1 << TOP_ORDER) - 1) >> TOP_ORDER;
	localparam logic [CNT_W-1:0] TOP_CNT = CNT_W'(TOP);
	localparam logic [ORD_W-1:0] MAX_O = ORD_W'(TOP_ORDER);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EX   = 3'd3;
	localparam logic [2:0] S_BUD  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]         state_q;
	logic               rep_q;
	logic [EW-1:0]      pg_q;
	logic [ORD_W-1:0]   o_q;
	logic [FIRST_W-1:0] first_q;
	logic [END_W-1:0]   end_q;
	logic [CNT_W-1:0]   cnt_q [TOP_ORDER+1];
	ent_t               mem [PAGE_COUNT];
	ent_t               rd_q;

	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	ent_t               mem_wd;
	logic [EW-1:0]      size, half, blk_end, nxt_pg, buddy;
	logic               hit, in_range, split, buddy_ok, last_pg;
	logic               cnt_init, cnt_dec;
	logic [1:0]         cnt_inc;
	logic [ADDR_W+1:0]  end_sum;
	logic               req_acc, rsp_acc;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign rsp.order = o_q;
	assign rsp.free_blocks = cnt_q[o_q];
	assign rsp.last = (o_q == '0);

	assign end_sum = {2'b00, req.base_address} + {2'b00, req.length_bytes}
		+ (ADDR_W+2)'((1 << PAGE_SH) - 1);

	// shared compare unit for the head under test
	assign size     = EW'(1) << o_q;
	assign half     = size >> 1;
	assign blk_end  = pg_q + size;
	assign nxt_pg   = pg_q + size;
	assign buddy    = pg_q + half;
	assign buddy_ok = (buddy < EW'(PAGE_COUNT));
	assign last_pg  = (nxt_pg >= EW'(PAGE_COUNT));
	assign hit = rd_q.free && (rd_q.ord == o_q)
		&& !(END_W'(blk_end) <= END_W'(first_q) || END_W'(pg_q) >= end_q);
	assign in_range = (END_W'(pg_q) >= END_W'(first_q)) && (END_W'(blk_end) <= end_q);
	assign split = hit && !in_range && (o_q != '0);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = pg_q[AW-1:0];
		mem_wd = '0;
		cnt_dec = 1'b0;
		cnt_inc = 2'd0;
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				if (pg_q[TOP_ORDER-1:0] == '0) begin
					mem_wd.free = 1'b1;
					mem_wd.ord = MAX_O;
				end
			end
			S_EX: begin
				if (hit) begin
					mem_we = 1'b1;
					cnt_dec = 1'b1;
					mem_wd.free = split;
					mem_wd.ord = split ? (o_q - ORD_W'(1)) : rd_q.ord;
					if (split)
						cnt_inc = buddy_ok ? 2'd2 : 2'd1;
				end
			end
			S_BUD: begin
				mem_we = 1'b1;
				mem_wa = buddy[AW-1:0];
				mem_wd.free = 1'b1;
				mem_wd.ord = o_q - ORD_W'(1);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[pg_q[AW-1:0]];
	end

	assign cnt_init = req_acc && (req.command == CMD_REINIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= TOP_ORDER; k++)
				cnt_q[k] <= (k == TOP_ORDER) ? TOP_CNT : '0;
		end else if (cnt_init) begin
			for (int k = 0; k <= TOP_ORDER; k++)
				cnt_q[k] <= (k == TOP_ORDER) ? TOP_CNT : '0;
		end else if (cnt_dec) begin
			for (int k = 0; k <= TOP_ORDER; k++) begin
				if (ORD_W'(k) == o_q)
					cnt_q[k] <= cnt_q[k] - CNT_W'(1);
				else if (ORD_W'(k) == o_q - ORD_W'(1) && o_q != '0)
					cnt_q[k] <= cnt_q[k] + CNT_W'(cnt_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			rep_q   <= 1'b0;
			pg_q    <= '0;
			o_q     <= MAX_O;
			first_q <= '0;
			end_q   <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					if (pg_q == EW'(PAGE_COUNT - 1)) begin
						pg_q <= '0;
						o_q <= MAX_O;
						state_q <= rep_q ? S_OUT : S_IDLE;
					end else begin
						pg_q <= pg_q + EW'(1);
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						pg_q <= '0;
						o_q <= MAX_O;
						first_q <= req.base_address[ADDR_W-1:PAGE_SH];
						end_q <= end_sum[PAGE_SH +: END_W];
						if (req.command == CMD_REINIT) begin
							rep_q <= 1'b1;
							state_q <= S_CLR;
						end else if (req.length_bytes == '0) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_EX;
				end
				S_EX, S_BUD: begin
					if (state_q == S_EX && split && buddy_ok) begin
						state_q <= S_BUD;
					end else if (last_pg) begin
						pg_q <= '0;
						if (o_q == '0) begin
							o_q <= MAX_O;
							state_q <= S_OUT;
						end else begin
							o_q <= o_q - ORD_W'(1);
							state_q <= S_RD;
						end
					end else begin
						pg_q <= nxt_pg;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					if (rsp_acc) begin
						if (o_q == '0) begin
							rep_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							o_q <= o_q - ORD_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// report runs stay ordered and end on order zero
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc && rsp.last |=> !rsp_valid)
		else $error("report continued after order zero");

	a_order_steps: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc && !rsp.last |=> rsp_valid && rsp.order == $past(rsp.order) - ORD_W'(1))
		else $error("report order did not step down by one");

	a_no_req_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request taken while reports pending");

	a_buddy_after_split: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BUD |-> $past(state_q) == S_EX && $past(split))
		else $error("buddy write without a split");

endmodule
